// ===== hdl/polygon_gate_point_test_assert.svh =====
// Assertion macros for the polygon gate point test block.
// Included by the top level; no other dependencies.
`ifndef POLYGON_GATE_POINT_TEST_ASSERT_SVH
`define POLYGON_GATE_POINT_TEST_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define PGPT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pgpt assertion failed");

// Next-cycle implication, disabled during reset.
`define PGPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pgpt assertion failed");

`else

`define PGPT_ASSERT_IMP(label, clk, rst, ante, cons)
`define PGPT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/pgpt_pkg.sv =====
// Shared types and constants for the polygon gate point test block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pgpt_pkg;

   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_COORD_BITS   = 32;

   // request function codes
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_TEST   = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_FEW  = 2'd2;

   // edge unit: four half-width partials for each of two products
   localparam int PP_STEPS  = 8;
   localparam int STEP_LAST = 9;
   localparam int STEP_BITS = 4;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FIRST = 5'b00010,
      S_EDGE  = 5'b00100,
      S_WAIT  = 5'b01000,
      S_FIN   = 5'b10000
   } pgpt_state_type;

   typedef struct packed {
      logic done;
      logic crossed;
   } pgpt_edge_res_type;

endpackage

`default_nettype wire

// ===== hdl/pgpt_edge_unit.sv =====
// Edge crossing unit: decides whether one polygon edge crosses the ray.
// Shared half-width multiplier, accumulated over cycles. Uses pgpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pgpt_edge_unit
   import pgpt_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [COORD_BITS-1:0] px,
   input  wire logic signed [COORD_BITS-1:0] py,
   input  wire logic signed [COORD_BITS-1:0] x0,
   input  wire logic signed [COORD_BITS-1:0] y0,
   input  wire logic signed [COORD_BITS-1:0] x1,
   input  wire logic signed [COORD_BITS-1:0] y1,
   output pgpt_edge_res_type                 res
);

   localparam int H  = (COORD_BITS + 1) / 2;
   localparam int MW = 2 * H;
   localparam int AW = 2 * MW + 2;

   logic signed [COORD_BITS:0] d_pa, d_pb, d_qa, d_qb;
   logic        [COORD_BITS:0] m_pa, m_pb, m_qa, m_qb;
   logic signed [COORD_BITS-1:0] lo_y, hi_y;
   logic                       span_c;

   logic [MW-1:0] mpa_ff, mpb_ff, mqa_ff, mqb_ff;
   logic          sp_ff, sq_ff, up_ff, span_ff;

   logic                 busy_ff;
   logic [STEP_BITS-1:0] cnt_ff;
   logic                 pp_vld_ff;
   logic [MW-1:0]        pp_ff;
   logic [1:0]           shift_ff;
   logic                 neg_ff;
   logic signed [AW-1:0] acc_ff, acc_in;

   logic [MW-1:0] opa, opb, pp_c;
   logic [H-1:0]  ha, hb;
   logic [AW-1:0] term;
   logic          mul_step;

   // D = (yp-y0)*(x1-x0) - (xp-x0)*(y1-y0), built from magnitudes and signs
   always_comb begin
      d_pa = $signed({py[COORD_BITS-1], py}) - $signed({y0[COORD_BITS-1], y0});
      d_pb = $signed({x1[COORD_BITS-1], x1}) - $signed({x0[COORD_BITS-1], x0});
      d_qa = $signed({px[COORD_BITS-1], px}) - $signed({x0[COORD_BITS-1], x0});
      d_qb = $signed({y1[COORD_BITS-1], y1}) - $signed({y0[COORD_BITS-1], y0});
      m_pa = d_pa[COORD_BITS] ? -d_pa : d_pa;
      m_pb = d_pb[COORD_BITS] ? -d_pb : d_pb;
      m_qa = d_qa[COORD_BITS] ? -d_qa : d_qa;
      m_qb = d_qb[COORD_BITS] ? -d_qb : d_qb;
      lo_y = (y0 < y1) ? y0 : y1;
      hi_y = (y0 < y1) ? y1 : y0;
      span_c = (y0 != y1) && (py > lo_y) && (py <= hi_y);
   end

   always_comb begin
      mul_step = busy_ff && (cnt_ff < STEP_BITS'(PP_STEPS));
      opa  = cnt_ff[2] ? mqa_ff : mpa_ff;
      opb  = cnt_ff[2] ? mqb_ff : mpb_ff;
      ha   = cnt_ff[1] ? opa[MW-1:H] : opa[H-1:0];
      hb   = cnt_ff[0] ? opb[MW-1:H] : opb[H-1:0];
      pp_c = MW'(ha) * MW'(hb);
      case (shift_ff)
         2'd0:    term = AW'(pp_ff);
         2'd1:    term = AW'(pp_ff) << H;
         default: term = AW'(pp_ff) << MW;
      endcase
      acc_in = neg_ff ? (acc_ff - $signed(term)) : (acc_ff + $signed(term));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         cnt_ff    <= '0;
         pp_vld_ff <= 1'b0;
      end else if (start) begin
         busy_ff   <= 1'b1;
         cnt_ff    <= span_c ? '0 : STEP_BITS'(STEP_LAST);
         pp_vld_ff <= 1'b0;
      end else if (busy_ff) begin
         pp_vld_ff <= mul_step;
         if (cnt_ff == STEP_BITS'(STEP_LAST)) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mpa_ff  <= MW'(m_pa[COORD_BITS-1:0]);
         mpb_ff  <= MW'(m_pb[COORD_BITS-1:0]);
         mqa_ff  <= MW'(m_qa[COORD_BITS-1:0]);
         mqb_ff  <= MW'(m_qb[COORD_BITS-1:0]);
         sp_ff   <= d_pa[COORD_BITS] ^ d_pb[COORD_BITS];
         sq_ff   <= d_qa[COORD_BITS] ^ d_qb[COORD_BITS];
         up_ff   <= y1 > y0;
         span_ff <= span_c;
         acc_ff  <= '0;
      end else if (pp_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (mul_step) begin
         pp_ff    <= pp_c;
         shift_ff <= {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
         // second product is subtracted
         neg_ff   <= cnt_ff[2] ? !sq_ff : sp_ff;
      end
   end

   always_comb begin
      res.done    = busy_ff && (cnt_ff == STEP_BITS'(STEP_LAST));
      res.crossed = span_ff && (up_ff ? (acc_ff[AW-1] || (acc_ff == '0))
                                      : !acc_ff[AW-1]);
   end

endmodule

`default_nettype wire

// ===== hdl/polygon_gate_point_test.sv =====
// Polygon gate point test: vertex store, bounding box and ray-cast point test.
// Uses pgpt_pkg, pgpt_edge_unit and polygon_gate_point_test_assert.svh.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   func, coord_x, coord_y
//   rsp_      out        rsp_valid/rsp_stall   inside_res, status, box_*
//
// Clear, append and a test on fewer than three vertices answer in the cycle
// after they are accepted. A test walks every edge through the edge unit, which
// forms 8 half-width partial products through the one shared multiplier and then
// drains the last when the point's y is inside the edge's span, else skips them.
// Reset clears the vertex count and box; the vertex store itself is not cleared.
// New requests wait while a test runs or while a response is held by rsp_stall.
`timescale 1ns / 1ps
`default_nettype none
`include "polygon_gate_point_test_assert.svh"

module polygon_gate_point_test
   import pgpt_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int COORD_BITS   = DEF_COORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_func,
   input  wire logic signed [COORD_BITS-1:0] req_coord_x,
   input  wire logic signed [COORD_BITS-1:0] req_coord_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_inside_res,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_box_valid,
   output logic signed [COORD_BITS-1:0]      rsp_box_x_low,
   output logic signed [COORD_BITS-1:0]      rsp_box_y_low,
   output logic signed [COORD_BITS-1:0]      rsp_box_x_high,
   output logic signed [COORD_BITS-1:0]      rsp_box_y_high
);

   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int IW = $clog2(MAX_VERTICES);

   logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] rd_x_ff, rd_y_ff;

   pgpt_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [COORD_BITS-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic signed [COORD_BITS-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic vhit_ff, vhit_in, par_ff, par_in;
   logic signed [COORD_BITS-1:0] minx_ff, minx_in, miny_ff, miny_in;
   logic signed [COORD_BITS-1:0] maxx_ff, maxx_in, maxy_ff, maxy_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_inside_ff, rsp_inside_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic rsp_bvalid_ff, rsp_bvalid_in;
   logic signed [COORD_BITS-1:0] rsp_xl_ff, rsp_xl_in, rsp_yl_ff, rsp_yl_in;
   logic signed [COORD_BITS-1:0] rsp_xh_ff, rsp_xh_in, rsp_yh_ff, rsp_yh_in;

   logic out_free, accept, rsp_load, wr_en, eu_start, at_wrap;
   logic signed [COORD_BITS-1:0] cur_x, cur_y;
   pgpt_edge_res_type eu_res;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign at_wrap   = (idx_ff == count_ff);
   // closing edge goes back to the first vertex
   assign cur_x     = at_wrap ? fx_ff : rd_x_ff;
   assign cur_y     = at_wrap ? fy_ff : rd_y_ff;

   pgpt_edge_unit #(
      .COORD_BITS(COORD_BITS)
   ) u_edge (
      .clock (clock),
      .reset (reset),
      .start (eu_start),
      .px    (px_ff),
      .py    (py_ff),
      .x0    (qx_ff),
      .y0    (qy_ff),
      .x1    (cur_x),
      .y1    (cur_y),
      .res   (eu_res)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      px_in = px_ff;  py_in = py_ff;
      fx_in = fx_ff;  fy_in = fy_ff;
      qx_in = qx_ff;  qy_in = qy_ff;
      vhit_in = vhit_ff;
      par_in  = par_ff;
      minx_in = minx_ff;  miny_in = miny_ff;
      maxx_in = maxx_ff;  maxy_in = maxy_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_xl_in = rsp_xl_ff;  rsp_yl_in = rsp_yl_ff;
      rsp_xh_in = rsp_xh_ff;  rsp_yh_in = rsp_yh_ff;
      rsp_load = 1'b0;
      wr_en    = 1'b0;
      eu_start = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_inside_in = 1'b0;
               rsp_status_in = STATUS_OK;
               case (req_func)
                  FUNC_CLEAR: begin
                     rsp_load = 1'b1;
                     count_in = '0;
                     minx_in = '0;  miny_in = '0;
                     maxx_in = '0;  maxy_in = '0;
                  end
                  FUNC_APPEND: begin
                     rsp_load = 1'b1;
                     if (count_ff == CW'(MAX_VERTICES)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (count_ff == '0) begin
                           minx_in = req_coord_x;  maxx_in = req_coord_x;
                           miny_in = req_coord_y;  maxy_in = req_coord_y;
                        end else begin
                           if (req_coord_x < minx_ff) minx_in = req_coord_x;
                           if (req_coord_y < miny_ff) miny_in = req_coord_y;
                           if (req_coord_x > maxx_ff) maxx_in = req_coord_x;
                           if (req_coord_y > maxy_ff) maxy_in = req_coord_y;
                        end
                     end
                  end
                  FUNC_TEST: begin
                     if (count_ff < CW'(3)) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STATUS_FEW;
                     end else begin
                        px_in    = req_coord_x;
                        py_in    = req_coord_y;
                        idx_in   = '0;
                        vhit_in  = 1'b0;
                        par_in   = 1'b0;
                        state_in = S_FIRST;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_FIRST: begin
            fx_in = rd_x_ff;  fy_in = rd_y_ff;
            qx_in = rd_x_ff;  qy_in = rd_y_ff;
            vhit_in  = (rd_x_ff == px_ff) && (rd_y_ff == py_ff);
            idx_in   = CW'(1);
            state_in = S_EDGE;
         end
         S_EDGE: begin
            eu_start = 1'b1;
            if (!at_wrap && (cur_x == px_ff) && (cur_y == py_ff)) begin
               vhit_in = 1'b1;
            end
            qx_in    = cur_x;
            qy_in    = cur_y;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (eu_res.done) begin
               par_in = par_ff ^ eu_res.crossed;
               if (at_wrap) begin
                  state_in = S_FIN;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_EDGE;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_inside_in = par_ff && !vhit_ff;
               rsp_status_in = STATUS_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_bvalid_in = (count_in != '0);
         rsp_xl_in = minx_in;  rsp_yl_in = miny_in;
         rsp_xh_in = maxx_in;  rsp_yh_in = maxy_in;
      end
   end

   // vertex store: written on append, read each cycle at the next walk index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[count_ff[IW-1:0]] <= req_coord_x;
         mem_y[count_ff[IW-1:0]] <= req_coord_y;
      end
      rd_x_ff <= mem_x[idx_in[IW-1:0]];
      rd_y_ff <= mem_y[idx_in[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         minx_ff      <= '0;
         miny_ff      <= '0;
         maxx_ff      <= '0;
         maxy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         minx_ff      <= minx_in;
         miny_ff      <= miny_in;
         maxx_ff      <= maxx_in;
         maxy_ff      <= maxy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;  py_ff <= py_in;
      fx_ff <= fx_in;  fy_ff <= fy_in;
      qx_ff <= qx_in;  qy_ff <= qy_in;
      vhit_ff <= vhit_in;
      par_ff  <= par_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_xl_ff <= rsp_xl_in;  rsp_yl_ff <= rsp_yl_in;
      rsp_xh_ff <= rsp_xh_in;  rsp_yh_ff <= rsp_yh_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_box_valid  = rsp_bvalid_ff;
   assign rsp_box_x_low  = rsp_xl_ff;
   assign rsp_box_y_low  = rsp_yl_ff;
   assign rsp_box_x_high = rsp_xh_ff;
   assign rsp_box_y_high = rsp_yh_ff;

   `PGPT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_VERTICES))
   `PGPT_ASSERT_IMP(a_walk_enough, clock, reset, state_ff == S_FIRST, count_ff >= CW'(3))
   `PGPT_ASSERT_IMP(a_idx_bound, clock, reset, state_ff != S_IDLE, idx_ff <= count_ff)
   `PGPT_ASSERT_NEXT(a_clear_empties, clock, reset, accept && (req_func == FUNC_CLEAR), (count_ff == '0) && rsp_valid_ff && !rsp_box_valid)

endmodule

`default_nettype wire

// ===== sim/tb_polygon_gate_point_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for polygon_gate_point_test: polygon load, clear and point requests.
// Needs pgpt_pkg and the RTL of the block; a local class tracks the store and checks responses.

module tb_polygon_gate_point_test;
   import pgpt_pkg::*;

   localparam int MAX_CORNERS = DEF_MAX_VERTICES;
   localparam int CB          = DEF_COORD_BITS;
   localparam int TOTAL_ITEMS = 1950;
   localparam int Q_ONE       = 1 << 16;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   typedef logic signed [CB-1:0] coord_type;

   localparam coord_type C_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam coord_type C_MIN = {1'b1, {(CB-1){1'b0}}};

   typedef enum {SCALE_GRID, SCALE_WIDE, SCALE_FULL, SCALE_EXTREME} scale_type;

   typedef struct packed {
      logic       in_poly;
      logic [1:0] status;
      logic       box_valid;
      coord_type  x_low;
      coord_type  y_low;
      coord_type  x_high;
      coord_type  y_high;
   } answer_type;

   class polygon_mirror;
      coord_type   corner_x[MAX_CORNERS];
      coord_type   corner_y[MAX_CORNERS];
      int unsigned corner_count;
      coord_type   low_x, low_y, high_x, high_y;
      answer_type  pending_answers[$];
      int unsigned faults, tests, hits, short_tests, drops;

      function new();
         corner_count = 0;
         low_x = 0;
         low_y = 0;
         high_x = 0;
         high_y = 0;
         faults = 0;
         tests = 0;
         hits = 0;
         short_tests = 0;
         drops = 0;
      endfunction

      // crossing parity of a ray towards -x; exact products, no division
      function bit ray_parity(coord_type px, coord_type py);
         int unsigned         crossings;
         int unsigned         j;
         coord_type           x0, y0, x1, y1, span_lo, span_hi;
         logic signed [127:0] a, b, lhs, rhs;
         crossings = 0;
         for (int i = 0; i < corner_count; i++)
            if (corner_x[i] == px && corner_y[i] == py)
               return 1'b0;
         for (int i = 0; i < corner_count; i++) begin
            j = (i + 1 == corner_count) ? 0 : i + 1;
            x0 = corner_x[i];
            y0 = corner_y[i];
            x1 = corner_x[j];
            y1 = corner_y[j];
            if (y0 == y1)
               continue;
            span_lo = (y0 < y1) ? y0 : y1;
            span_hi = (y0 < y1) ? y1 : y0;
            if (py > span_lo && py <= span_hi) begin
               a = py - y0;
               b = x1 - x0;
               lhs = a * b;
               a = px - x0;
               b = y1 - y0;
               rhs = a * b;
               if ((y1 > y0) ? (lhs <= rhs) : (lhs >= rhs))
                  crossings++;
            end
         end
         return crossings[0];
      endfunction

      function void take_request(logic [1:0] func, coord_type x, coord_type y);
         answer_type ans;
         ans = '0;
         ans.status = STATUS_OK;
         case (func)
            FUNC_CLEAR: begin
               corner_count = 0;
               low_x = 0;
               low_y = 0;
               high_x = 0;
               high_y = 0;
            end
            FUNC_APPEND: begin
               if (corner_count >= MAX_CORNERS) begin
                  ans.status = STATUS_FULL;
                  drops++;
               end else begin
                  if (corner_count == 0) begin
                     low_x = x;
                     high_x = x;
                     low_y = y;
                     high_y = y;
                  end else begin
                     if (x < low_x) low_x = x;
                     if (y < low_y) low_y = y;
                     if (x > high_x) high_x = x;
                     if (y > high_y) high_y = y;
                  end
                  corner_x[corner_count] = x;
                  corner_y[corner_count] = y;
                  corner_count++;
               end
            end
            FUNC_TEST: begin
               tests++;
               if (corner_count < 3) begin
                  ans.status = STATUS_FEW;
                  short_tests++;
               end else begin
                  ans.in_poly = ray_parity(x, y);
                  hits += ans.in_poly;
               end
            end
            default: ;
         endcase
         if (corner_count > 0) begin
            ans.box_valid = 1'b1;
            ans.x_low = low_x;
            ans.y_low = low_y;
            ans.x_high = high_x;
            ans.y_high = high_y;
         end
         pending_answers = {pending_answers, ans};
      endfunction

      function void compare_field(string what, logic [CB-1:0] want, logic [CB-1:0] got);
         if (want !== got) begin
            faults++;
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
         end
      endfunction

      function void match_response(answer_type got);
         answer_type want;
         if (pending_answers.size() == 0) begin
            faults++;
            $display("%0t: response with nothing outstanding, expected none actual %h",
                     $time, got);
            return;
         end
         want = pending_answers.pop_front();
         compare_field("inside_res", want.in_poly, got.in_poly);
         compare_field("status", want.status, got.status);
         compare_field("box_valid", want.box_valid, got.box_valid);
         compare_field("box_x_low", want.x_low, got.x_low);
         compare_field("box_y_low", want.y_low, got.y_low);
         compare_field("box_x_high", want.x_high, got.x_high);
         compare_field("box_y_high", want.y_high, got.y_high);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_func = FUNC_CLEAR;
   coord_type  req_coord_x = '0;
   coord_type  req_coord_y = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_inside_res;
   logic [1:0] rsp_status;
   logic       rsp_box_valid;
   coord_type  rsp_box_x_low, rsp_box_y_low, rsp_box_x_high, rsp_box_y_high;

   polygon_mirror mirror;
   int unsigned   requests_sent = 0;
   int unsigned   req_gap_max = 6;
   int unsigned   stall_max = 6;
   int unsigned   stall_left = 0;
   coord_type     shape_x[$];
   coord_type     shape_y[$];

   polygon_gate_point_test dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_inside_res (rsp_inside_res),
      .rsp_status     (rsp_status),
      .rsp_box_valid  (rsp_box_valid),
      .rsp_box_x_low  (rsp_box_x_low),
      .rsp_box_y_low  (rsp_box_y_low),
      .rsp_box_x_high (rsp_box_x_high),
      .rsp_box_y_high (rsp_box_y_high)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // request noted before response checked, so a same-edge pair stays in order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            mirror.take_request(req_func, req_coord_x, req_coord_y);
         if (rsp_valid && !rsp_stall)
            mirror.match_response({rsp_inside_res, rsp_status, rsp_box_valid,
                                   rsp_box_x_low, rsp_box_y_low,
                                   rsp_box_x_high, rsp_box_y_high});
      end
   end

   // each response is held for a freshly drawn number of valid cycles
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         stall_left = $urandom_range(0, stall_max);
      else if (rsp_valid && rsp_stall && stall_left > 0)
         stall_left--;
      rsp_stall <= (stall_left > 0);
   end

   function automatic coord_type draw_coord(scale_type scale);
      case (scale)
         SCALE_GRID: return coord_type'((int'($urandom_range(0, 12)) - 6) * Q_ONE);
         SCALE_WIDE: return coord_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
         SCALE_FULL: return coord_type'($urandom);
         default: begin
            case ($urandom_range(0, 4))
               0: return C_MIN;
               1: return C_MAX;
               2: return coord_type'(0);
               3: return coord_type'(-1);
               default: return C_MIN + 1;
            endcase
         end
      endcase
   endfunction

   task automatic send_request(logic [1:0] func, coord_type x, coord_type y);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_coord_x <= x;
      req_coord_y <= y;
      do @(posedge clock); while (req_stall);
      if (func == FUNC_CLEAR) begin
         shape_x.delete();
         shape_y.delete();
      end else if (func == FUNC_APPEND && shape_x.size() < MAX_CORNERS) begin
         shape_x = {shape_x, x};
         shape_y = {shape_y, y};
      end
      requests_sent++;
   endtask

   // probe points: stored corners, side midpoints, extremes or the polygon's scale
   task automatic pick_probe(scale_type scale, output coord_type px, output coord_type py);
      int unsigned roll, k, m;
      roll = $urandom_range(0, 9);
      if (roll < 4 && shape_x.size() > 0) begin
         k = $urandom_range(0, shape_x.size() - 1);
         if (roll < 2) begin
            px = shape_x[k];
            py = shape_y[k];
         end else begin
            m = (k + 1 == shape_x.size()) ? 0 : k + 1;
            px = coord_type'((longint'(shape_x[k]) + longint'(shape_x[m])) >>> 1);
            py = coord_type'((longint'(shape_y[k]) + longint'(shape_y[m])) >>> 1);
         end
      end else if (roll == 4) begin
         px = draw_coord(SCALE_EXTREME);
         py = draw_coord(SCALE_EXTREME);
      end else if (scale == SCALE_GRID) begin
         px = coord_type'((int'($urandom_range(0, 26)) - 13) * (Q_ONE / 2));
         py = coord_type'((int'($urandom_range(0, 26)) - 13) * (Q_ONE / 2));
      end else begin
         px = draw_coord(scale);
         py = draw_coord(scale);
      end
   endtask

   task automatic run_directed();
      send_request(FUNC_CLEAR, C_MAX, C_MIN);
      send_request(FUNC_TEST, C_MIN, C_MAX);            // empty store
      send_request(FUNC_SPARE, coord_type'(-1), coord_type'(-1));
      send_request(FUNC_APPEND, C_MAX, C_MIN);
      send_request(FUNC_APPEND, C_MIN, C_MAX);
      send_request(FUNC_TEST, coord_type'(0), coord_type'(0)); // two corners only
      send_request(FUNC_APPEND, C_MAX, C_MAX);
      send_request(FUNC_TEST, coord_type'(0), coord_type'(0));
      send_request(FUNC_TEST, C_MAX, C_MIN);
      send_request(FUNC_TEST, C_MIN, C_MIN);
      send_request(FUNC_TEST, coord_type'(Q_ONE), C_MAX - 1);
      send_request(FUNC_CLEAR, coord_type'(0), coord_type'(0));
      // square with horizontal top and bottom sides
      send_request(FUNC_APPEND, coord_type'(0), coord_type'(0));
      send_request(FUNC_APPEND, coord_type'(4 * Q_ONE), coord_type'(0));
      send_request(FUNC_APPEND, coord_type'(4 * Q_ONE), coord_type'(4 * Q_ONE));
      send_request(FUNC_APPEND, coord_type'(0), coord_type'(4 * Q_ONE));
      send_request(FUNC_TEST, coord_type'(2 * Q_ONE), coord_type'(2 * Q_ONE));
      send_request(FUNC_TEST, coord_type'(0), coord_type'(2 * Q_ONE));
      send_request(FUNC_TEST, coord_type'(4 * Q_ONE), coord_type'(2 * Q_ONE));
      send_request(FUNC_TEST, coord_type'(2 * Q_ONE), coord_type'(0));
      send_request(FUNC_TEST, coord_type'(2 * Q_ONE), coord_type'(4 * Q_ONE));
      send_request(FUNC_TEST, coord_type'(4 * Q_ONE), coord_type'(4 * Q_ONE));
      send_request(FUNC_SPARE, coord_type'(Q_ONE), coord_type'(Q_ONE));
      send_request(FUNC_TEST, coord_type'(-Q_ONE), coord_type'(-Q_ONE));
   endtask

   task automatic run_random();
      int unsigned n_corners, n_probes, roll;
      scale_type   scale;
      coord_type   px, py;
      bit          first;
      first = 1'b1;
      while (requests_sent < TOTAL_ITEMS) begin
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
         stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
         if (!first && $urandom_range(0, 9) == 0) begin
            // noise: any function, any coordinates
            repeat ($urandom_range(1, 6))
               send_request(2'($urandom_range(0, 3)), coord_type'($urandom),
                            coord_type'($urandom));
         end else begin
            roll = $urandom_range(0, 9);
            scale = (roll < 6) ? SCALE_GRID : (roll < 8) ? SCALE_WIDE :
                    (roll < 9) ? SCALE_FULL : SCALE_EXTREME;
            // an occasional overfill runs into the store limit
            if (first || $urandom_range(0, 9) == 0)
               n_corners = $urandom_range(60, 70);
            else
               n_corners = $urandom_range(0, 9);
            if (first || $urandom_range(0, 7) != 0)
               send_request(FUNC_CLEAR, coord_type'($urandom), coord_type'($urandom));
            repeat (n_corners)
               send_request(FUNC_APPEND, draw_coord(scale), draw_coord(scale));
            n_probes = $urandom_range(1, 8);
            repeat (n_probes) begin
               roll = $urandom_range(0, 19);
               if (roll == 0)
                  send_request(FUNC_SPARE, coord_type'($urandom), coord_type'($urandom));
               else if (roll == 1)
                  send_request(FUNC_APPEND, draw_coord(scale), draw_coord(scale));
               pick_probe(scale, px, py);
               send_request(FUNC_TEST, px, py);
            end
         end
         first = 1'b0;
      end
   endtask

   initial begin
      mirror = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (mirror.pending_answers.size() != 0)
         @(posedge clock);
      repeat (720) @(posedge clock);
      $display("run: %0d requests, %0d point tests, %0d inside, %0d short of corners",
               requests_sent, mirror.tests, mirror.hits, mirror.short_tests);
      $display("run: %0d appends dropped on a full store, %0d field mismatches",
               mirror.drops, mirror.faults);
      if (mirror.faults == 0)
         $display("polygon_gate_point_test: match");
      else
         $display("polygon_gate_point_test: mismatch");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d responses outstanding", mirror.pending_answers.size());
      $display("polygon_gate_point_test: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pgpt_pkg.sv
hdl/pgpt_edge_unit.sv
hdl/polygon_gate_point_test.sv
sim/tb_polygon_gate_point_test.sv
